FILE: rtl/core/esort_pkg.sv
// shared types and sizes for the exchange sort engine
// no dependencies; compiled first
package esort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 32;
  localparam int TAG_W       = 16;
  localparam int REC_W       = KEY_W + TAG_W;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH_I,
    S_LATCH_I,
    S_SCAN,
    S_WRITE_I,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_SHOW
  } state_t;

endpackage

FILE: rtl/core/esort_if.sv
// valid/ready channel interfaces for record input and sorted output
// depends on esort_pkg for field widths
interface esort_in_if import esort_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] record_key;
  logic [TAG_W-1:0] record_tag;
  logic             last_record;

  modport source (output valid, record_key, record_tag, last_record, input ready);
  modport sink   (input valid, record_key, record_tag, last_record, output ready);
endinterface

interface esort_out_if import esort_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             final_result;
  logic             overflowed;

  modport source (output valid, sorted_key, sorted_tag, final_result, overflowed,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, final_result, overflowed,
                  output ready);
endinterface

FILE: rtl/core/exchange_sort_engine.sv
// top level of the exchange sort engine: record ram plus sequencer
// depends on esort_pkg, esort_if, esort_ram, esort_seq
//
//  channel  dir  handshake       beat
//  in_ch    in   valid / ready   record_key, record_tag, last_record
//  out_ch   out  valid / ready   sorted_key, sorted_tag, final_result, overflowed
//
// loading: ready is high throughout the load state; it stays low from the last
// beat until the final result has gone out. the sort of n records uses the
// single comparator and the one-read-port ram, and runs when n >= 2.
// emission: S_OUT_RD, then S_OUT_LD and S_OUT_SHOW per result; stalls on out_ch.
// synchronous reset empties the set; ram contents need no clearing.
module exchange_sort_engine import esort_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  esort_in_if.sink   in_ch,
  esort_out_if.source out_ch
);

  rec_t     in_rec;
  rec_t     out_rec;
  rec_t     mem_rdata;
  mem_req_t mem_req;
  logic     [REC_W-1:0] rdata_raw;

  assign in_rec.key = in_ch.record_key;
  assign in_rec.tag = in_ch.record_tag;
  assign mem_rdata  = rec_t'(rdata_raw);

  esort_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

  esort_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_rec    (in_rec),
    .in_last   (in_ch.last_record),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rec   (out_rec),
    .out_final (out_ch.final_result),
    .out_ovf   (out_ch.overflowed)
  );

  assign out_ch.sorted_key = out_rec.key;
  assign out_ch.sorted_tag = out_rec.tag;

endmodule

FILE: rtl/core/esort_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module esort_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/esort_seq.sv
// sequencer and shared key comparator: load, exchange sort, emit
// depends on esort_pkg; drives the record ram through a mem_req_t
module esort_seq import esort_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rec_t     in_rec,
  input  logic     in_last,
  output mem_req_t mem_req,
  input  rec_t     mem_rdata,
  output logic     out_valid,
  input  logic     out_ready,
  output rec_t     out_rec,
  output logic     out_final,
  output logic     out_ovf
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  rec_t             cur_r, cur_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CNT_W-1:0] last_pos;
  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] k_inc;
  logic             in_fire;
  logic             swap;

  assign last_pos = count_r - CNT_W'(1);
  assign j_inc    = j_r + CNT_W'(1);
  assign i_inc    = i_r + CNT_W'(1);
  assign k_inc    = k_r + CNT_W'(1);
  assign in_fire  = in_valid && in_ready;
  assign swap     = cur_r.key > mem_rdata.key;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = (count_nxt >= CNT_W'(2)) ? S_FETCH_I : S_OUT_RD;
        end
      end
      S_FETCH_I: state_nxt = S_LATCH_I;
      S_LATCH_I: state_nxt = S_SCAN;
      S_SCAN: begin
        if (j_r == last_pos) begin
          state_nxt = S_WRITE_I;
        end
      end
      S_WRITE_I: begin
        state_nxt = (i_r + CNT_W'(2) < count_r) ? S_LATCH_I : S_OUT_RD;
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: state_nxt = S_OUT_SHOW;
      S_OUT_SHOW: begin
        if (out_ready) begin
          state_nxt = out_last_r ? S_LOAD : S_OUT_LD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    out_rec_nxt  = out_rec_r;
    out_last_nxt = out_last_r;
    mem_req      = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        i_nxt    = '0;
        k_nxt    = '0;
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count_r[IDX_W-1:0];
            mem_req.wdata = in_rec;
            count_nxt     = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_FETCH_I: begin
        mem_req.raddr = i_r[IDX_W-1:0];
        j_nxt         = i_inc;
      end
      S_LATCH_I: begin
        cur_nxt       = mem_rdata;
        mem_req.raddr = j_r[IDX_W-1:0];
      end
      S_SCAN: begin
        mem_req.raddr = j_inc[IDX_W-1:0];
        if (swap) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = j_r[IDX_W-1:0];
          mem_req.wdata = cur_r;
          cur_nxt       = mem_rdata;
        end
        if (j_r != last_pos) begin
          j_nxt = j_inc;
        end
      end
      S_WRITE_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r[IDX_W-1:0];
        mem_req.wdata = cur_r;
        mem_req.raddr = i_inc[IDX_W-1:0];
        i_nxt         = i_inc;
        j_nxt         = i_r + CNT_W'(2);
      end
      S_OUT_RD: begin
        mem_req.raddr = k_r[IDX_W-1:0];
      end
      S_OUT_LD: begin
        out_rec_nxt   = mem_rdata;
        out_last_nxt  = (k_r == last_pos);
        mem_req.raddr = k_inc[IDX_W-1:0];
      end
      S_OUT_SHOW: begin
        out_valid     = 1'b1;
        mem_req.raddr = k_inc[IDX_W-1:0];
        if (out_ready) begin
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            k_nxt = k_inc;
          end
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_rec   = out_rec_r;
  assign out_final = out_last_r;
  assign out_ovf   = ovf_r;

endmodule

FILE: rtl/core/esort_chk.sv
// port-level checker for the exchange sort engine, bound to the top level
// depends on esort_pkg and exchange_sort_engine
module esort_chk import esort_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_final,
  input logic [KEY_W-1:0] out_key,
  input logic [TAG_W-1:0] out_tag,
  input logic             out_ovf
);

  // loading and emitting never overlap
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is shown");

  // last beat closes the input side
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still ready after last beat");

  // final result reopens the input side
  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_final) |=> in_ready && !out_valid)
    else $error("input not ready after final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_key) && $stable(out_tag)
      && $stable(out_final) && $stable(out_ovf))
    else $error("stalled result changed");

endmodule

bind exchange_sort_engine esort_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_record),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_final (out_ch.final_result),
  .out_key   (out_ch.sorted_key),
  .out_tag   (out_ch.sorted_tag),
  .out_ovf   (out_ch.overflowed)
);
